// File: hw/rtl/msit_pkg.sv
// Shared types and constants for the multi-slot interval timer.
`default_nettype none

package msit_pkg;

  localparam int unsigned Slots    = 16;
  localparam int unsigned SlotBits = 4;
  localparam int unsigned TimeBits = 32;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_ALLOC    = 3'd1,
    CMD_RESTART  = 3'd2,
    CMD_TOGGLE   = 3'd3,
    CMD_CONTINUE = 3'd4,
    CMD_PAUSE    = 3'd5,
    CMD_STOP     = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_UNUSED = 2'd2
  } status_e;

  typedef enum logic {
    KIND_FIRE = 1'b0,
    KIND_ACK  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [SlotBits-1:0] slot;
    logic [31:0]         interval;
    logic                start_now;
  } msit_in_t;

  typedef struct packed {
    logic                kind;
    logic [SlotBits-1:0] slot_id;
    logic [1:0]          status;
    logic                last;
  } msit_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/multi_slot_interval_timer.sv
// Multi-slot interval timer: tick counter, slot table and a one-slot-per-cycle scanner.
//
// Usage: items enter on the in channel (in_valid_i / in_stall_o, payload
// in_data_i) and results leave on the out channel (out_valid_o /
// out_stall_i, payload out_data_o). A beat moves when valid is high and
// stall is low. One item is worked on at a time; in_stall_o is high while
// it is in progress.
// A command beat yields one acknowledgement, loaded into the output
// register in the EXEC state once that register is free; the block
// then returns to idle and takes the next item, while the
// acknowledgement may still wait downstream. A tick beat advances the
// counter and then scans the slot table with one shared compare and
// adder, one slot per cycle unless stalled: an accept step, one scan
// step per slot for all 16 slots and a close-out step. Each fire result
// is held one step back so the final one can carry last; a tick with
// no fires yields nothing. A stalled receiver freezes the scan at the
// next firing slot until the output register frees up; no result is
// dropped. Reset clears the counter, the in-use and running flags and all
// handshake state. Period and due entries are written by allocation before use.
`default_nettype none

module multi_slot_interval_timer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire msit_pkg::msit_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output msit_pkg::msit_out_t     out_data_o
);

  localparam int unsigned SB = msit_pkg::SlotBits;
  localparam int unsigned TB = msit_pkg::TimeBits;
  localparam logic [SB:0] ScanEnd = (SB+1)'(msit_pkg::Slots);

  msit_pkg::state_e    state_q, state_d;
  msit_pkg::msit_in_t  cmd_q, cmd_d;
  logic [TB-1:0]       now_q, now_d;
  logic [msit_pkg::Slots-1:0] in_use_q, in_use_d;
  logic [msit_pkg::Slots-1:0] running_q, running_d;
  logic [SB:0]         idx_q, idx_d;
  logic                pend_valid_q, pend_valid_d;
  logic [SB-1:0]       pend_id_q, pend_id_d;
  logic                out_valid_q, out_valid_d;
  msit_pkg::msit_out_t out_q, out_d;

  // slot table storage
  logic [TB-1:0] period_mem [msit_pkg::Slots];
  logic [TB-1:0] due_mem    [msit_pkg::Slots];

  logic          per_we, due_we;
  logic [SB-1:0] per_waddr, due_waddr;
  logic [TB-1:0] per_wdata, due_wdata;

  logic [SB-1:0] scan_slot, rd_addr;
  logic [TB-1:0] due_rd_q, per_rd_q;
  logic [TB-1:0] add_a, add_b, add_sum;
  logic          out_free;
  logic          free_found;
  logic [SB-1:0] free_id;
  logic          fire;
  logic [SB-1:0] s;

  assign scan_slot = idx_q[SB-1:0];
  assign s         = cmd_q.slot;
  // fetch the entry for the slot that the scan looks at next
  assign rd_addr   = idx_d[SB-1:0];
  assign add_sum   = add_a + add_b;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fire      = in_use_q[scan_slot] && running_q[scan_slot] && (now_q > due_rd_q);

  assign in_stall_o  = (state_q != msit_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = msit_pkg::Slots - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_id    = SB'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    now_d        = now_q;
    in_use_d     = in_use_q;
    running_d    = running_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    per_we       = 1'b0;
    per_waddr    = s;
    per_wdata    = cmd_q.interval[TB-1:0];
    due_we       = 1'b0;
    due_waddr    = s;
    due_wdata    = now_q;
    add_a        = now_q;
    add_b        = cmd_q.interval[TB-1:0];

    case (state_q)
      msit_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_data_i;
          if (in_data_i.cmd == msit_pkg::CMD_TICK) begin
            now_d        = now_q + TB'(1);
            idx_d        = '0;
            pend_valid_d = 1'b0;
            state_d      = msit_pkg::S_SCAN;
          end else begin
            state_d = msit_pkg::S_EXEC;
          end
        end
      end

      msit_pkg::S_EXEC: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.kind    = msit_pkg::KIND_ACK;
          out_d.slot_id = s;
          out_d.status  = msit_pkg::STAT_OK;
          out_d.last    = 1'b1;
          state_d       = msit_pkg::S_IDLE;
          if (cmd_q.cmd == msit_pkg::CMD_ALLOC) begin
            if (!free_found) begin
              out_d.slot_id = '0;
              out_d.status  = msit_pkg::STAT_FULL;
            end else begin
              out_d.slot_id      = free_id;
              in_use_d[free_id]  = 1'b1;
              running_d[free_id] = 1'b1;
              per_we             = 1'b1;
              per_waddr          = free_id;
              due_we             = 1'b1;
              due_waddr          = free_id;
              due_wdata          = cmd_q.start_now ? now_q : add_sum;
            end
          end else if (!in_use_q[s]) begin
            out_d.status = msit_pkg::STAT_UNUSED;
          end else begin
            case (cmd_q.cmd)
              msit_pkg::CMD_RESTART: begin
                per_we = 1'b1;
                if (!running_q[s]) begin
                  running_d[s] = 1'b1;
                  due_we       = 1'b1;
                end
              end
              msit_pkg::CMD_TOGGLE: begin
                running_d[s] = !running_q[s];
                due_we       = !running_q[s];
              end
              msit_pkg::CMD_CONTINUE: begin
                running_d[s] = 1'b1;
                due_we       = 1'b1;
                if (cmd_q.interval != '0) begin
                  per_we    = 1'b1;
                  due_wdata = add_sum;
                end
              end
              msit_pkg::CMD_PAUSE: begin
                running_d[s] = 1'b0;
              end
              msit_pkg::CMD_STOP: begin
                in_use_d[s]  = 1'b0;
                running_d[s] = 1'b0;
              end
              default: begin
                // unknown code: leave the table alone
                out_d.status = msit_pkg::STAT_UNUSED;
              end
            endcase
          end
        end
      end

      msit_pkg::S_SCAN: begin
        add_a = due_rd_q;
        add_b = per_rd_q;
        if (idx_q == ScanEnd) begin
          // flush the held fire as the final result
          if (!pend_valid_q) begin
            state_d = msit_pkg::S_IDLE;
          end else if (out_free) begin
            out_valid_d   = 1'b1;
            out_d.kind    = msit_pkg::KIND_FIRE;
            out_d.slot_id = pend_id_q;
            out_d.status  = msit_pkg::STAT_OK;
            out_d.last    = 1'b1;
            pend_valid_d  = 1'b0;
            state_d       = msit_pkg::S_IDLE;
          end
        end else if (fire) begin
          // hold the scan while a held fire cannot move out
          if (!pend_valid_q || out_free) begin
            due_we    = 1'b1;
            due_waddr = scan_slot;
            due_wdata = add_sum;
            if (pend_valid_q) begin
              out_valid_d   = 1'b1;
              out_d.kind    = msit_pkg::KIND_FIRE;
              out_d.slot_id = pend_id_q;
              out_d.status  = msit_pkg::STAT_OK;
              out_d.last    = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = scan_slot;
            idx_d        = idx_q + (SB+1)'(1);
          end
        end else begin
          idx_d = idx_q + (SB+1)'(1);
        end
      end

      default: begin
        state_d = msit_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= msit_pkg::S_IDLE;
      now_q        <= '0;
      in_use_q     <= '0;
      running_q    <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      in_use_q     <= in_use_d;
      running_q    <= running_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (per_we) begin
      period_mem[per_waddr] <= per_wdata;
    end
    if (due_we) begin
      due_mem[due_waddr] <= due_wdata;
    end
    due_rd_q <= due_mem[rd_addr];
    per_rd_q <= period_mem[rd_addr];
  end

endmodule

`default_nettype wire
